// ===== design/delayed_accumulation_ring_assert.svh =====
// ----------------------------------------------------------------------------
// delayed_accumulation_ring_assert.svh
// Assertion macros used by the delayed accumulation ring top module.
// ----------------------------------------------------------------------------
`ifndef DELAYED_ACCUMULATION_RING_ASSERT_SVH
`define DELAYED_ACCUMULATION_RING_ASSERT_SVH

// Same-cycle implication, checked outside reset
`define DAR_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("same-cycle check failed");

// Next-cycle implication, checked outside reset
`define DAR_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("next-cycle check failed");

`endif

// ===== design/dar_pkg.sv =====
// ----------------------------------------------------------------------------
// dar_pkg
// Field widths, reset values and action codes of the accumulation ring.
// ----------------------------------------------------------------------------
package dar_pkg;

    localparam int unsigned ACTION_W = 2;
    localparam int unsigned SAMPLE_W = 24;
    localparam int unsigned INDEX_W  = 12;
    localparam int unsigned LEN_W    = 13;
    localparam int unsigned COUNT_W  = 32;

    localparam logic [LEN_W-1:0] LEN_RESET = 13'd4096;

    typedef enum logic [ACTION_W-1:0] {
        ACT_ACCUM   = 2'd0,
        ACT_READ    = 2'd1,
        ACT_CLEAR   = 2'd2,
        ACT_ADVANCE = 2'd3
    } t_action;

endpackage

// ===== design/dar_if.sv =====
// ----------------------------------------------------------------------------
// dar_if
// Request and result channels of the accumulation ring, valid/ready handshake.
// ----------------------------------------------------------------------------
interface dar_in_if;
    import dar_pkg::*;

    logic                       valid;
    logic                       ready;
    logic [ACTION_W-1:0]        action;
    logic signed [SAMPLE_W-1:0] sample_in;
    logic [INDEX_W-1:0]         caller_index;
    logic [INDEX_W-1:0]         delay_frames;

    modport source (
        output valid, action, sample_in, caller_index, delay_frames,
        input  ready
    );
    modport sink (
        input  valid, action, sample_in, caller_index, delay_frames,
        output ready
    );
endinterface

interface dar_out_if;
    import dar_pkg::*;

    logic                       valid;
    logic                       ready;
    logic signed [SAMPLE_W-1:0] sample_out;
    logic [INDEX_W-1:0]         write_slot;
    logic [INDEX_W-1:0]         next_caller_index;
    logic [COUNT_W-1:0]         frames_read;
    logic                       error;

    modport source (
        output valid, sample_out, write_slot, next_caller_index, frames_read, error,
        input  ready
    );
    modport sink (
        input  valid, sample_out, write_slot, next_caller_index, frames_read, error,
        output ready
    );
endinterface

// ===== design/delayed_accumulation_ring.sv =====
// ----------------------------------------------------------------------------
// delayed_accumulation_ring
// Overlap-add accumulation ring: saturating accumulate, read-and-clear,
// clear-all and index advance over a ring of samples held in one RAM.
// ----------------------------------------------------------------------------
//  channel   dir  handshake      payload
//  i_in      in   valid/ready    action, sample_in, caller_index, delay_frames
//  o_out     out  valid/ready    sample_out, write_slot, next_caller_index,
//                                frames_read, error
//  i_cfg_*   in   write enable   buffer_length
//
//  Each request issues the RAM read on acceptance and writes the modified value
//  back from the RAM's registered read data in the execute state, once the
//  output register is free.
//  After reset and after every clear_all the RAM is swept to zero, all MAX_DEPTH
//  entries, with i_in.ready low.
//  A pending result sits in the output register; a new request is still taken
//  and waits in the execute cycle until the output register frees.
// ----------------------------------------------------------------------------
`include "delayed_accumulation_ring_assert.svh"

module delayed_accumulation_ring #(
    parameter int unsigned MAX_DEPTH   = 4096,
    parameter int unsigned SAMPLE_BITS = 24
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_cfg_wr_en,
    input  logic [dar_pkg::LEN_W-1:0]   i_cfg_wr_data,
    dar_in_if.sink                      i_in,
    dar_out_if.source                   o_out
);
    import dar_pkg::*;

    localparam int unsigned AW = $clog2(MAX_DEPTH);
    localparam int unsigned LW = (AW + 1 > LEN_W) ? AW + 1 : LEN_W;
    localparam logic [AW-1:0] SWEEP_LAST = AW'(MAX_DEPTH - 1);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_EXEC,
        ST_SWEEP
    } t_state;

    // Control state
    t_state                  r_state, n_state;
    logic [AW-1:0]           r_sweep, n_sweep;
    logic [AW-1:0]           r_rd_ptr, n_rd_ptr;
    logic [COUNT_W-1:0]      r_read_count, n_read_count;
    logic [LEN_W-1:0]        r_buf_len, n_buf_len;
    logic                    r_out_valid, n_out_valid;

    // Request held for the execute cycle
    t_action                 r_op, n_op;
    logic                    r_err, n_err;
    logic                    r_rmw, n_rmw;
    logic [AW-1:0]           r_waddr, n_waddr;
    logic [INDEX_W-1:0]      r_slot_out, n_slot_out;
    logic [INDEX_W-1:0]      r_next, n_next;
    logic signed [SAMPLE_W-1:0] r_sample, n_sample;

    // Result register
    logic signed [SAMPLE_W-1:0] r_out_sample, n_out_sample;
    logic [INDEX_W-1:0]      r_out_slot, n_out_slot;
    logic [INDEX_W-1:0]      r_out_next, n_out_next;
    logic [COUNT_W-1:0]      r_out_count, n_out_count;
    logic                    r_out_err, n_out_err;

    // Decode and RAM signals
    logic                    w_in_acc;
    logic                    w_fire;
    logic [LW-1:0]           w_cfg_ext, w_len;
    logic [LW-1:0]           w_caller, w_delay, w_cinc, w_cnext;
    logic [LW:0]             w_sum, w_slot;
    logic [LW-1:0]           w_rp, w_rpinc, w_rpnext;
    logic                    w_acc_err, w_idx_err, w_rp_err;
    logic                    w_ram_we, w_ram_re;
    logic [AW-1:0]           w_ram_waddr, w_ram_raddr;
    logic [SAMPLE_BITS-1:0]  w_ram_wdata, w_rd_data;
    logic signed [SAMPLE_BITS-1:0] w_sat;

    assign w_in_acc = i_in.valid && i_in.ready;
    assign w_fire   = (r_state == ST_EXEC) && (!r_out_valid || o_out.ready);

    // Clamp the configured length to 1..MAX_DEPTH
    assign w_cfg_ext = LW'(r_buf_len);
    assign w_len = (r_buf_len == '0) ? LW'(1) :
                   ((w_cfg_ext > LW'(MAX_DEPTH)) ? LW'(MAX_DEPTH) : w_cfg_ext);

    // Target slot and wrapped caller index
    assign w_caller  = LW'(i_in.caller_index);
    assign w_delay   = LW'(i_in.delay_frames);
    assign w_sum     = {1'b0, w_caller} + {1'b0, w_delay};
    assign w_slot    = (w_sum >= {1'b0, w_len}) ? (w_sum - {1'b0, w_len}) : w_sum;
    assign w_cinc    = w_caller + LW'(1);
    assign w_cnext   = (w_cinc >= w_len) ? '0 : w_cinc;
    assign w_idx_err = (w_caller >= w_len);
    assign w_acc_err = w_idx_err || (w_delay >= w_len);

    // Wrapped read pointer
    assign w_rp     = LW'(r_rd_ptr);
    assign w_rpinc  = w_rp + LW'(1);
    assign w_rpnext = (w_rpinc >= w_len) ? '0 : w_rpinc;
    assign w_rp_err = (w_rp >= w_len);

    // Next-state logic
    always_comb begin
        n_state      = r_state;
        n_sweep      = r_sweep;
        n_rd_ptr     = r_rd_ptr;
        n_read_count = r_read_count;
        n_buf_len    = i_cfg_wr_en ? i_cfg_wr_data : r_buf_len;
        n_out_valid  = r_out_valid && !o_out.ready;
        n_op         = r_op;
        n_err        = r_err;
        n_rmw        = r_rmw;
        n_waddr      = r_waddr;
        n_slot_out   = r_slot_out;
        n_next       = r_next;
        n_sample     = r_sample;
        n_out_sample = r_out_sample;
        n_out_slot   = r_out_slot;
        n_out_next   = r_out_next;
        n_out_count  = r_out_count;
        n_out_err    = r_out_err;
        w_ram_re     = 1'b0;
        w_ram_raddr  = r_rd_ptr;
        w_ram_we     = 1'b0;
        w_ram_waddr  = r_waddr;
        w_ram_wdata  = (r_op == ACT_READ) ? '0 : w_sat;

        unique case (r_state)
            ST_IDLE: begin
                if (w_in_acc) begin
                    n_state    = ST_EXEC;
                    n_op       = t_action'(i_in.action);
                    n_sample   = i_in.sample_in;
                    n_err      = 1'b0;
                    n_rmw      = 1'b0;
                    n_slot_out = '0;
                    n_next     = '0;
                    unique case (t_action'(i_in.action))
                        ACT_ACCUM: begin
                            if (w_acc_err) begin
                                n_err = 1'b1;
                            end else begin
                                n_rmw       = 1'b1;
                                n_waddr     = w_slot[AW-1:0];
                                n_slot_out  = w_slot[INDEX_W-1:0];
                                n_next      = w_cnext[INDEX_W-1:0];
                                w_ram_re    = 1'b1;
                                w_ram_raddr = w_slot[AW-1:0];
                            end
                        end
                        ACT_READ: begin
                            if (w_rp_err) begin
                                n_err = 1'b1;
                            end else begin
                                n_rmw        = 1'b1;
                                n_waddr      = r_rd_ptr;
                                n_rd_ptr     = w_rpnext[AW-1:0];
                                n_read_count = r_read_count + COUNT_W'(1);
                                w_ram_re     = 1'b1;
                                w_ram_raddr  = r_rd_ptr;
                            end
                        end
                        ACT_CLEAR: begin
                            n_rd_ptr     = '0;
                            n_read_count = '0;
                        end
                        ACT_ADVANCE: begin
                            if (w_idx_err) begin
                                n_err = 1'b1;
                            end else begin
                                n_next = w_cnext[INDEX_W-1:0];
                            end
                        end
                    endcase
                end
            end
            ST_EXEC: begin
                if (w_fire) begin
                    w_ram_we     = r_rmw;
                    n_out_valid  = 1'b1;
                    n_out_sample = (r_rmw && (r_op == ACT_READ)) ?
                                   SAMPLE_W'($signed(w_rd_data)) : '0;
                    n_out_slot   = r_slot_out;
                    n_out_next   = r_next;
                    n_out_count  = r_read_count;
                    n_out_err    = r_err;
                    if (r_op == ACT_CLEAR) begin
                        n_state = ST_SWEEP;
                        n_sweep = '0;
                    end else begin
                        n_state = ST_IDLE;
                    end
                end
            end
            ST_SWEEP: begin
                w_ram_we    = 1'b1;
                w_ram_waddr = r_sweep;
                w_ram_wdata = '0;
                if (r_sweep == SWEEP_LAST) begin
                    n_state = ST_IDLE;
                end else begin
                    n_sweep = r_sweep + AW'(1);
                end
            end
            default: begin
                n_state = ST_SWEEP;
            end
        endcase
    end

    // State and output registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= ST_SWEEP;
            r_sweep      <= '0;
            r_rd_ptr     <= '0;
            r_read_count <= '0;
            r_buf_len    <= LEN_RESET;
            r_out_valid  <= 1'b0;
        end else begin
            r_state      <= n_state;
            r_sweep      <= n_sweep;
            r_rd_ptr     <= n_rd_ptr;
            r_read_count <= n_read_count;
            r_buf_len    <= n_buf_len;
            r_out_valid  <= n_out_valid;
            r_op         <= n_op;
            r_err        <= n_err;
            r_rmw        <= n_rmw;
            r_waddr      <= n_waddr;
            r_slot_out   <= n_slot_out;
            r_next       <= n_next;
            r_sample     <= n_sample;
            r_out_sample <= n_out_sample;
            r_out_slot   <= n_out_slot;
            r_out_next   <= n_out_next;
            r_out_count  <= n_out_count;
            r_out_err    <= n_out_err;
        end
    end

    // Ring store
    dar_ram #(
        .DEPTH (MAX_DEPTH),
        .WIDTH (SAMPLE_BITS),
        .AW    (AW)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (w_ram_we),
        .i_waddr (w_ram_waddr),
        .i_wdata (w_ram_wdata),
        .i_re    (w_ram_re),
        .i_raddr (w_ram_raddr),
        .o_rdata (w_rd_data)
    );

    // Saturating accumulate of the slot just read
    dar_sat #(
        .SAMPLE_BITS (SAMPLE_BITS)
    ) u_sat (
        .i_slot   ($signed(w_rd_data)),
        .i_sample (r_sample),
        .o_sum    (w_sat)
    );

    // Drive the channels
    assign i_in.ready              = (r_state == ST_IDLE);
    assign o_out.valid             = r_out_valid;
    assign o_out.sample_out        = r_out_sample;
    assign o_out.write_slot        = r_out_slot;
    assign o_out.next_caller_index = r_out_next;
    assign o_out.frames_read       = r_out_count;
    assign o_out.error             = r_out_err;

    // Checks
    `DAR_ASSERT_NEXT(a_accept_to_exec, i_clk, i_rst_n, w_in_acc, r_state == ST_EXEC)
    `DAR_ASSERT_NEXT(a_fire_loads_out, i_clk, i_rst_n, w_fire, o_out.valid)
    `DAR_ASSERT_NOW(a_sweep_counters_zero, i_clk, i_rst_n, r_state == ST_SWEEP,
                    (r_rd_ptr == '0) && (r_read_count == '0))
    `DAR_ASSERT_NOW(a_write_when_owned, i_clk, i_rst_n, w_ram_we,
                    (r_state == ST_EXEC) || (r_state == ST_SWEEP))

endmodule

// ===== design/dar_ram.sv =====
// ----------------------------------------------------------------------------
// dar_ram
// Simple dual-port synchronous RAM, one write and one registered read port.
// ----------------------------------------------------------------------------
module dar_ram #(
    parameter int unsigned DEPTH = 4096,
    parameter int unsigned WIDTH = 24,
    parameter int unsigned AW    = 12
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic             i_re,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // Write port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // Read port, data held until the next read
    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// ===== design/dar_sat.sv =====
// ----------------------------------------------------------------------------
// dar_sat
// Saturating adder: stored slot value plus an incoming Q1.23 sample.
// ----------------------------------------------------------------------------
module dar_sat #(
    parameter int unsigned SAMPLE_BITS = 24
) (
    input  logic signed [SAMPLE_BITS-1:0]       i_slot,
    input  logic signed [dar_pkg::SAMPLE_W-1:0] i_sample,
    output logic signed [SAMPLE_BITS-1:0]       o_sum
);
    import dar_pkg::*;

    localparam int unsigned SW = ((SAMPLE_BITS > SAMPLE_W) ? SAMPLE_BITS : SAMPLE_W) + 1;
    localparam logic signed [SW-1:0] HI =
        {{(SW - SAMPLE_BITS + 1){1'b0}}, {(SAMPLE_BITS - 1){1'b1}}};
    localparam logic signed [SW-1:0] LO = ~HI;

    logic signed [SW-1:0] w_sum;

    // Exact sum in a width that cannot overflow
    assign w_sum = SW'(i_slot) + SW'(i_sample);

    // Clamp to the stored sample range
    always_comb begin
        if (w_sum > HI) begin
            o_sum = HI[SAMPLE_BITS-1:0];
        end else if (w_sum < LO) begin
            o_sum = LO[SAMPLE_BITS-1:0];
        end else begin
            o_sum = w_sum[SAMPLE_BITS-1:0];
        end
    end

endmodule
